>>> src/cpnc_pkg.sv
// Shared types for the cluster nearest-centroid block.
// Holds the controller/datapath command and status structs; no dependencies.
package cpnc_pkg;

    localparam int NUM_AXES = 3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic store;       // take the input beat into the store and the sums
        logic clear;       // drop the cluster state for the next cluster
        logic div_load;    // load sum magnitudes into the dividers
        logic div_step;    // one quotient bit on every axis
        logic cent_load;   // fix signs, latch the centroid, rewind the scan
        logic scan_issue;  // read one stored point into the distance pipe
        logic out_load;    // move the best point to the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_last;    // current step is the final quotient bit
        logic scan_last;   // current issue reads the last stored point
        logic pipe_busy;   // distance pipe still holds points
        logic out_free;    // output register empty or being drained
    } t_status;

endpackage

>>> src/cpnc_ctrl.sv
// Sequencer for the cluster nearest-centroid block.
// Uses cpnc_pkg command and status types.
module cpnc_ctrl
    import cpnc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last_point,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_ready
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_DINIT = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_CENT  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_take;

    assign o_in_ready = (r_state == ST_LOAD);
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_LOAD: begin
                o_cmd.store = w_take;
                if (w_take && i_last_point) begin
                    n_state = ST_DINIT;
                end
            end
            ST_DINIT: begin
                o_cmd.div_load = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_CENT;
                end
            end
            ST_CENT: begin
                o_cmd.cent_load = 1'b1;
                n_state         = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_state        = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/cpnc_datapath.sv
// Datapath: point store, coordinate sums, bit-serial dividers,
// distance pipeline and output register. Uses cpnc_pkg.
module cpnc_datapath
    import cpnc_pkg::*;
#(
    parameter int MAX_POINTS = 4096,
    parameter int COORD_BITS = 20,
    parameter int INDEX_BITS = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_status                      o_status,
    input  logic        [INDEX_BITS-1:0] i_point_index,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic        [INDEX_BITS-1:0] o_key_index,
    output logic signed [COORD_BITS-1:0] o_key_x,
    output logic signed [COORD_BITS-1:0] o_key_y,
    output logic signed [COORD_BITS-1:0] o_key_z,
    output logic                         o_overflowed
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SUM_W  = COORD_BITS + CNT_W;
    localparam int DIVC_W = $clog2(SUM_W);
    localparam int ENT_W  = INDEX_BITS + NUM_AXES * COORD_BITS;
    localparam int DIF_W  = COORD_BITS + 1;
    localparam int DW     = 2 * COORD_BITS + 2;

    // Point store
    logic [ENT_W-1:0] mem [MAX_POINTS];

    logic        [CNT_W-1:0]      r_count;
    logic signed [SUM_W-1:0]      r_sum   [NUM_AXES];
    logic                         r_ovf;
    logic signed [COORD_BITS-1:0] w_pt    [NUM_AXES];
    logic                         w_full;

    // Dividers
    logic [SUM_W-1:0]  r_q   [NUM_AXES];
    logic [CNT_W-1:0]  r_rem [NUM_AXES];
    logic              r_neg [NUM_AXES];
    logic [DIVC_W-1:0] r_div_cnt;
    logic [SUM_W-1:0]  n_q   [NUM_AXES];
    logic [CNT_W-1:0]  n_rem [NUM_AXES];
    logic [SUM_W-1:0]  w_cent_full [NUM_AXES];

    // Scan and distance pipeline
    logic signed [COORD_BITS-1:0] r_cent [NUM_AXES];
    logic [ADDR_W-1:0]            r_addr;
    logic [ENT_W-1:0]             r_rd;
    logic [ENT_W-1:0]             r_p2;
    logic [ENT_W-1:0]             r_p3;
    logic [ENT_W-1:0]             r_p4;
    logic                         r_v1;
    logic                         r_v2;
    logic                         r_v3;
    logic                         r_v4;
    logic signed [COORD_BITS-1:0] w_rd_c [NUM_AXES];
    logic signed [DIF_W-1:0]      r_d    [NUM_AXES];
    logic signed [DW-1:0]         w_d_ext[NUM_AXES];
    logic [DW-1:0]                r_sq   [NUM_AXES];
    logic [DW-1:0]                r_dist;
    logic [DW-1:0]                r_best_d;
    logic [ENT_W-1:0]             r_best_p;
    logic                         r_best_ok;

    // Output register
    logic                  r_out_valid;
    logic [ENT_W-1:0]      r_out_p;
    logic                  r_out_ovf;

    assign w_pt[0] = i_point_x;
    assign w_pt[1] = i_point_y;
    assign w_pt[2] = i_point_z;
    assign w_full  = (r_count == CNT_W'(MAX_POINTS));

    // Store and sums
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && !w_full) begin
            mem[r_count[ADDR_W-1:0]] <= {i_point_index, i_point_x, i_point_y, i_point_z};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_sum[a] <= '0;
            end
        end else if (i_cmd.store) begin
            if (w_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + CNT_W'(1);
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_sum[a] <= r_sum[a] + SUM_W'(w_pt[a]);
                end
            end
        end
    end

    // Restoring division of |sum| by count, one bit per cycle per axis
    always_comb begin
        logic [CNT_W:0] shifted;
        logic [CNT_W:0] trial;
        for (int a = 0; a < NUM_AXES; a++) begin
            shifted = {r_rem[a], r_q[a][SUM_W-1]};
            trial   = shifted - {1'b0, r_count};
            if (!trial[CNT_W]) begin
                n_rem[a] = trial[CNT_W-1:0];
                n_q[a]   = {r_q[a][SUM_W-2:0], 1'b1};
            end else begin
                n_rem[a] = shifted[CNT_W-1:0];
                n_q[a]   = {r_q[a][SUM_W-2:0], 1'b0};
            end
            // floor toward minus infinity: -q, or -q-1 when a remainder is left
            if (r_neg[a]) begin
                w_cent_full[a] = (r_rem[a] != '0) ? ~r_q[a] : (~r_q[a] + SUM_W'(1));
            end else begin
                w_cent_full[a] = r_q[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div_cnt <= DIVC_W'(SUM_W - 1);
            for (int a = 0; a < NUM_AXES; a++) begin
                r_neg[a] <= r_sum[a][SUM_W-1];
                r_q[a]   <= r_sum[a][SUM_W-1] ? (~r_sum[a] + SUM_W'(1)) : r_sum[a];
                r_rem[a] <= '0;
            end
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - DIVC_W'(1);
            for (int a = 0; a < NUM_AXES; a++) begin
                r_q[a]   <= n_q[a];
                r_rem[a] <= n_rem[a];
            end
        end
        if (i_cmd.cent_load) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_cent[a] <= w_cent_full[a][COORD_BITS-1:0];
            end
        end
    end

    // Scan address and registered store read
    always_ff @(posedge i_clk) begin
        if (i_cmd.cent_load) begin
            r_addr <= '0;
        end else if (i_cmd.scan_issue) begin
            r_addr <= r_addr + ADDR_W'(1);
        end
        if (i_cmd.scan_issue) begin
            r_rd <= mem[r_addr];
        end
    end

    assign w_rd_c[0] = r_rd[3*COORD_BITS-1:2*COORD_BITS];
    assign w_rd_c[1] = r_rd[2*COORD_BITS-1:COORD_BITS];
    assign w_rd_c[2] = r_rd[COORD_BITS-1:0];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_d_ext[a] = DW'(r_d[a]);
        end
    end

    // Distance pipe: difference, square, sum, compare
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            r_d[a]  <= DIF_W'(r_cent[a]) - DIF_W'(w_rd_c[a]);
            r_sq[a] <= w_d_ext[a] * w_d_ext[a];
        end
        r_p2   <= r_rd;
        r_p3   <= r_p2;
        r_p4   <= r_p3;
        r_dist <= r_sq[0] + r_sq[1] + r_sq[2];
        if (r_v4 && (!r_best_ok || (r_dist < r_best_d))) begin
            r_best_d <= r_dist;
            r_best_p <= r_p4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_best_ok <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (i_cmd.cent_load) begin
                r_best_ok <= 1'b0;
            end else if (r_v4) begin
                r_best_ok <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_p   <= r_best_p;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_key_index  = r_out_p[ENT_W-1:3*COORD_BITS];
    assign o_key_x      = r_out_p[3*COORD_BITS-1:2*COORD_BITS];
    assign o_key_y      = r_out_p[2*COORD_BITS-1:COORD_BITS];
    assign o_key_z      = r_out_p[COORD_BITS-1:0];
    assign o_overflowed = r_out_ovf;

    assign o_status.div_last  = (r_div_cnt == '0);
    assign o_status.scan_last = (CNT_W'(r_addr) == (r_count - CNT_W'(1)));
    assign o_status.pipe_busy = r_v1 || r_v2 || r_v3 || r_v4;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule

>>> src/cluster_point_nearest_centroid.sv
// Top level of the cluster nearest-centroid block.
// Instantiates cpnc_ctrl and cpnc_datapath; uses cpnc_pkg.
//
//   channel | direction | handshake               | beat
//   --------+-----------+-------------------------+--------------------------------------
//   point   | in        | i_in_valid / o_in_ready | index, x, y, z, last_point
//   key     | out       | o_out_valid/i_out_ready | key index, x, y, z, overflowed flag
//
// Points load at one per cycle; a beat that finds the store full is dropped
// and raises the overflow flag. After the last beat the block loads the
// dividers, runs the bit-serial division into SUM_W-bit quotients (SUM_W =
// COORD_BITS + clog2(MAX_POINTS+1), 33 by default), latches the centroid,
// reads the store once per stored point (one read at a time, as the store has
// a single read port), drains the distance pipe and loads the result. The
// point channel stays closed from the last beat until the result is loaded.
// The result register lets the next cluster load while a key beat waits; a
// finished cluster holds until that key is taken. Reset (synchronous, active
// low) clears the count, sums and flags; the store itself needs no clearing,
// since only entries of the current cluster are read.
module cluster_point_nearest_centroid
    import cpnc_pkg::*;
#(
    parameter int MAX_POINTS = 4096,
    parameter int COORD_BITS = 20,
    parameter int INDEX_BITS = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic        [INDEX_BITS-1:0] i_point_index,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic                         i_last_point,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic        [INDEX_BITS-1:0] o_key_index,
    output logic signed [COORD_BITS-1:0] o_key_x,
    output logic signed [COORD_BITS-1:0] o_key_y,
    output logic signed [COORD_BITS-1:0] o_key_z,
    output logic                         o_overflowed
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequence load, divide, scan and hand-off
    cpnc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_point (i_last_point),
        .i_status     (w_status),
        .o_cmd        (w_cmd),
        .o_in_ready   (o_in_ready)
    );

    // Store, sums, dividers, distance pipe and result register
    cpnc_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_point_index (i_point_index),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_key_index   (o_key_index),
        .o_key_x       (o_key_x),
        .o_key_y       (o_key_y),
        .o_key_z       (o_key_z),
        .o_overflowed  (o_overflowed)
    );

endmodule
